// ----- sv/spq_pkg.sv -----
// Shared types and constants for the sorted priority job queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned PRI_W   = 8;
  localparam int unsigned PAY_W   = 32;
  localparam int unsigned ENTRY_W = PRI_W + PAY_W;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FETCH,
    S_FIN
  } seq_state_e;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [PAY_W-1:0] pay;
  } entry_t;

  typedef struct packed {
    status_e          status;
    logic [PRI_W-1:0] pri;
    logic [PAY_W-1:0] pay;
  } result_t;

endpackage

// ----- sv/spq_if.sv -----
// Request and response channel interfaces of the sorted priority job queue.
`timescale 1ns / 1ps

interface job_req_if import spq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [PRI_W-1:0] in_priority;
  logic [PAY_W-1:0] in_payload;

  modport source (output valid, output operation, output in_priority, output in_payload,
                  input ready);
  modport sink   (input valid, input operation, input in_priority, input in_payload,
                  output ready);
endinterface

interface job_rsp_if import spq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [PRI_W-1:0] out_priority;
  logic [PAY_W-1:0] out_payload;
  logic [CNT_W-1:0] job_count;
  logic [CNT_W-1:0] free_slots;

  modport source (output valid, output status, output out_priority, output out_payload,
                  output job_count, output free_slots, input ready);
  modport sink   (input valid, input status, input out_priority, input out_payload,
                  input job_count, input free_slots, output ready);
endinterface

// ----- sv/spq_ram.sv -----
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module spq_ram #(
  parameter int unsigned DATA_W    = 40,
  parameter int unsigned NUM_WORDS = 16,
  parameter int unsigned ADDR_W    = $clog2(NUM_WORDS)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [NUM_WORDS];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/sorted_priority_job_queue_core.sv -----
// Sorted priority job queue: a sequencer walks the entry store to insert and serve jobs.
// Jobs sit in the store sorted by priority value, largest at slot 0, so the job to serve is
// always the top occupied slot. One request is in flight at a time; req.ready is high only
// while the sequencer is idle, and a finished response may wait in the output register
// while the next request is taken. An enqueue shifts every stored job with equal or smaller
// priority value up one slot (at most DEPTH - 1 of them); each shift is one read and one
// write of the two-port entry store. Dequeue and peek do one store read; rejects and the
// unused code do none.
`timescale 1ns / 1ps

module sorted_priority_job_queue_core import spq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  job_req_if.sink   req_i,
  job_rsp_if.source rsp_o
);

  seq_state_e       state_q, state_d;
  op_e              op_q;
  logic [PRI_W-1:0] pri_q;
  logic [PAY_W-1:0] pay_q;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  result_t          res_q, res_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_res_q, out_res_d;
  logic [CNT_W-1:0] out_cnt_q, out_cnt_d;

  logic              accept;
  logic              rsp_take;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  entry_t            wdata;
  logic [ADDR_W-1:0] raddr;
  entry_t            rdata;

  spq_ram #(
    .DATA_W   (ENTRY_W),
    .NUM_WORDS(DEPTH),
    .ADDR_W   (ADDR_W)
  ) u_spq_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_take    = out_valid_q && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(req_i.operation);
      pri_q <= req_i.in_priority;
      pay_q <= req_i.in_payload;
    end
    idx_q     <= idx_d;
    res_q     <= res_d;
    out_res_q <= out_res_d;
    out_cnt_q <= out_cnt_d;
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !rsp_take;
    out_res_d   = out_res_q;
    out_cnt_d   = out_cnt_q;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = '{pri: pri_q, pay: pay_q};
    raddr       = idx_q - ADDR_W'(2);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '{status: ST_OK, pri: '0, pay: '0};
          case (op_e'(req_i.operation))
            OP_ENQ: begin
              if (req_i.in_priority == '0) begin
                res_d.status = ST_ZERO;
                state_d      = S_FIN;
              end else if (count_q == CNT_W'(DEPTH)) begin
                res_d.status = ST_FULL;
                state_d      = S_FIN;
              end else begin
                idx_d   = count_q[ADDR_W-1:0];
                raddr   = count_q[ADDR_W-1:0] - ADDR_W'(1);
                state_d = S_WALK;
              end
            end
            OP_DEQ, OP_PEEK: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
                state_d      = S_FIN;
              end else begin
                raddr   = count_q[ADDR_W-1:0] - ADDR_W'(1);
                state_d = S_FETCH;
              end
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_WALK: begin
        we    = 1'b1;
        waddr = idx_q;
        if (idx_q == '0 || rdata.pri > pri_q) begin
          wdata   = '{pri: pri_q, pay: pay_q};
          count_d = count_q + CNT_W'(1);
          state_d = S_FIN;
        end else begin
          wdata = rdata;
          idx_d = idx_q - ADDR_W'(1);
          raddr = idx_q - ADDR_W'(2);
        end
      end
      S_FETCH: begin
        res_d = '{status: ST_OK, pri: rdata.pri, pay: rdata.pay};
        if (op_q == OP_DEQ) begin
          count_d = count_q - CNT_W'(1);
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || rsp_take) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_cnt_d   = count_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_res_q.status;
  assign rsp_o.out_priority = out_res_q.pri;
  assign rsp_o.out_payload  = out_res_q.pay;
  assign rsp_o.job_count    = out_cnt_q;
  assign rsp_o.free_slots   = CNT_W'(DEPTH) - out_cnt_q;

endmodule

// ----- sv/spq_checker.sv -----
// Port-level assertions for the sorted priority job queue, bound to the top level.
`timescale 1ns / 1ps

module spq_checker import spq_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [1:0]       status_i,
  input logic [PRI_W-1:0] out_priority_i,
  input logic [PAY_W-1:0] out_payload_i,
  input logic [CNT_W-1:0] job_count_i,
  input logic [CNT_W-1:0] free_slots_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (int'(job_count_i) + int'(free_slots_i)) == int'(DEPTH))
    else $error("job count and free slots disagree");

  a_error_no_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_EMPTY || status_i == ST_FULL || status_i == ST_ZERO)
    |-> out_priority_i == '0 && out_payload_i == '0)
    else $error("error response carries a job");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous transaction in flight");

  a_zero_pri_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_OK && out_priority_i == '0 |-> out_payload_i == '0)
    else $error("payload returned without a stored job");

endmodule

bind sorted_priority_job_queue_core spq_checker u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .out_priority_i(rsp_o.out_priority),
  .out_payload_i (rsp_o.out_payload),
  .job_count_i   (rsp_o.job_count),
  .free_slots_i  (rsp_o.free_slots)
);
